>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the button action controller RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/btlr_pkg.sv
// Types and constants of the button action controller.
// Depends on nothing; imported by every module of the block.
package btlr_pkg;

    localparam logic [9:0] REPEAT_DELAY = 10'd350;
    localparam logic [9:0] REPEAT_STEP  = 10'd55;
    localparam logic [9:0] LONG_PRESS   = 10'd600;
    localparam logic [9:0] GHOST_WINDOW = 10'd250;

    typedef enum logic [2:0] {
        OP_PRESS       = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_TICK        = 3'd2,
        OP_FLUSH_ARMED = 3'd3,
        OP_RELEASE_ALL = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_DOWN   = 3'd0,
        ACT_UP     = 3'd1,
        ACT_TAP    = 3'd2,
        ACT_LONG   = 3'd3,
        ACT_REPEAT = 3'd4,
        ACT_WHEEL  = 3'd5
    } action_t;

    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_LATCH = 2'd2;

    localparam logic [2:0] MOUSE_LEFT       = 3'd1;
    localparam logic [2:0] MOUSE_RIGHT      = 3'd2;
    localparam logic [2:0] MOUSE_MIDDLE     = 3'd3;
    localparam logic [2:0] MOUSE_WHEEL_UP   = 3'd4;
    localparam logic [2:0] MOUSE_WHEEL_DOWN = 3'd5;

    typedef enum logic [2:0] {
        CFG_KEY_ENABLED    = 3'd0,
        CFG_BUTTON_MODE    = 3'd1,
        CFG_MOUSE_ACTION   = 3'd2,
        CFG_HAS_COMBO      = 3'd3,
        CFG_HAS_LONG_COMBO = 3'd4,
        CFG_REPEAT_ENABLE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic       key_enabled;
        logic [1:0] button_mode;
        logic [2:0] mouse_action;
        logic       has_combo;
        logic       has_long_combo;
        logic       repeat_enable;
    } btlr_cfg_t;

    // Up to three actions caused by one event, first action in slot 0.
    typedef struct packed {
        logic [1:0]          count;
        logic [2:0][2:0]     act;
    } btlr_bundle_t;

endpackage

>>> hw/rtl/btlr_front.sv
// Front end: accepts events, keeps the button state and classifies each
// event into a bundle of actions. Depends on btlr_pkg.
module btlr_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  btlr_pkg::btlr_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic [31:0]          now_ms,
    input  logic                 cursor_on_panel,
    input  logic                 full,
    output logic                 push,
    output btlr_pkg::btlr_bundle_t bundle
);
    import btlr_pkg::*;

    logic                 down_reg, down_next;
    logic                 latched_reg, latched_next;
    logic                 armed_reg, armed_next;
    logic                 long_reg, long_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] next_rep_reg, next_rep_next;
    logic [TIME_BITS-1:0] toggle_reg, toggle_next;

    logic [63:0]          now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] d_tog, d_long, d_rep;
    logic                 ghost, long_due, rep_due;
    logic                 accept;
    logic                 is_latch, is_hold, is_tap, mouse_btn, mouse_whl, active;
    logic [1:0]           n_cnt;
    logic [2:0][2:0]      act_arr;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    assign now_ext = {32'd0, now_ms};
    assign now_t   = now_ext[TIME_BITS-1:0];

    assign d_tog  = now_t - toggle_reg;
    assign d_long = now_t - press_time_reg;
    assign d_rep  = now_t - next_rep_reg;

    assign ghost    = d_tog[TIME_BITS-1] || (d_tog < TIME_BITS'(GHOST_WINDOW));
    assign long_due = !d_long[TIME_BITS-1] && !(d_long < TIME_BITS'(LONG_PRESS));
    assign rep_due  = !d_rep[TIME_BITS-1];

    assign is_latch  = cfg.button_mode == MODE_LATCH;
    assign is_hold   = cfg.button_mode == MODE_HOLD;
    assign is_tap    = !is_latch && !is_hold;
    assign mouse_btn = cfg.mouse_action inside {MOUSE_LEFT, MOUSE_RIGHT, MOUSE_MIDDLE};
    assign mouse_whl = cfg.mouse_action inside {MOUSE_WHEEL_UP, MOUSE_WHEEL_DOWN};
    assign active    = is_latch ? latched_reg : down_reg;

    always_comb
    begin
        down_next       = down_reg;
        latched_next    = latched_reg;
        armed_next      = armed_reg;
        long_next       = long_reg;
        press_time_next = press_time_reg;
        next_rep_next   = next_rep_reg;
        toggle_next     = toggle_reg;
        n_cnt           = 2'd0;
        act_arr         = '0;
        if (accept && cfg.key_enabled)
        begin
            case (opcode_t'(opcode))
                OP_PRESS:
                begin
                    down_next       = 1'b1;
                    press_time_next = now_t;
                    long_next       = 1'b0;
                    next_rep_next   = now_t + TIME_BITS'(REPEAT_DELAY);
                    if (is_latch)
                    begin
                        if (!down_reg && !ghost)
                        begin
                            toggle_next = now_t;
                            if (latched_reg)
                            begin
                                if (!armed_reg)
                                begin
                                    act_arr[0] = ACT_UP;
                                    n_cnt      = 2'd1;
                                end
                                latched_next = 1'b0;
                                armed_next   = 1'b0;
                            end
                            else
                            begin
                                latched_next = 1'b1;
                                if (mouse_btn && cursor_on_panel)
                                begin
                                    armed_next = 1'b1;
                                end
                                else
                                begin
                                    act_arr[0] = ACT_DOWN;
                                    n_cnt      = 2'd1;
                                end
                            end
                        end
                    end
                    else if (is_hold)
                    begin
                        if (mouse_btn && cursor_on_panel)
                        begin
                            armed_next = 1'b1;
                        end
                        else
                        begin
                            act_arr[0] = ACT_DOWN;
                            n_cnt      = 2'd1;
                        end
                    end
                    else if (!cfg.has_long_combo)
                    begin
                        act_arr[0] = ACT_TAP;
                        n_cnt      = 2'd1;
                    end
                end
                OP_RELEASE:
                begin
                    down_next = 1'b0;
                    if (is_hold)
                    begin
                        if (armed_reg)
                        begin
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            act_arr[0] = ACT_UP;
                            n_cnt      = 2'd1;
                        end
                    end
                    else
                    begin
                        if (is_tap && cfg.has_long_combo && !long_reg)
                        begin
                            act_arr[0] = ACT_TAP;
                            n_cnt      = 2'd1;
                        end
                        long_next = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    if (armed_reg && !cursor_on_panel)
                    begin
                        armed_next = 1'b0;
                        act_arr[0] = ACT_DOWN;
                        n_cnt      = 2'd1;
                    end
                    if (down_reg && !long_reg && cfg.has_long_combo && long_due)
                    begin
                        long_next      = 1'b1;
                        act_arr[n_cnt] = ACT_LONG;
                        n_cnt          = n_cnt + 2'd1;
                    end
                    if (cfg.repeat_enable && active && !armed_next && rep_due)
                    begin
                        next_rep_next = now_t + TIME_BITS'(REPEAT_STEP);
                        if (is_tap)
                        begin
                            act_arr[n_cnt] = ACT_TAP;
                            n_cnt          = n_cnt + 2'd1;
                        end
                        else if (cfg.has_combo)
                        begin
                            act_arr[n_cnt] = ACT_REPEAT;
                            n_cnt          = n_cnt + 2'd1;
                        end
                        else if (mouse_whl)
                        begin
                            act_arr[n_cnt] = ACT_WHEEL;
                            n_cnt          = n_cnt + 2'd1;
                        end
                    end
                end
                OP_FLUSH_ARMED:
                begin
                    if (armed_reg)
                    begin
                        armed_next = 1'b0;
                        act_arr[0] = ACT_DOWN;
                        n_cnt      = 2'd1;
                    end
                end
                OP_RELEASE_ALL:
                begin
                    if ((latched_reg || down_reg) && !armed_reg)
                    begin
                        act_arr[0] = ACT_UP;
                        n_cnt      = 2'd1;
                    end
                    latched_next = 1'b0;
                    down_next    = 1'b0;
                    armed_next   = 1'b0;
                    long_next    = 1'b0;
                end
                default:
                begin
                    n_cnt = 2'd0;
                end
            endcase
        end
    end

    assign push         = accept && (n_cnt != 2'd0);
    assign bundle.count = n_cnt;
    assign bundle.act   = act_arr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg       <= 1'b0;
            latched_reg    <= 1'b0;
            armed_reg      <= 1'b0;
            long_reg       <= 1'b0;
            press_time_reg <= '0;
            next_rep_reg   <= '0;
            toggle_reg     <= '0;
        end
        else
        begin
            down_reg       <= down_next;
            latched_reg    <= latched_next;
            armed_reg      <= armed_next;
            long_reg       <= long_next;
            press_time_reg <= press_time_next;
            next_rep_reg   <= next_rep_next;
            toggle_reg     <= toggle_next;
        end
    end

endmodule

>>> hw/rtl/btlr_queue.sv
// Short queue of action bundles between the front and back ends.
// Depends on btlr_pkg and assert_macros.svh.
module btlr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  btlr_pkg::btlr_bundle_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   q_valid,
    output btlr_pkg::btlr_bundle_t q_data
);
    import btlr_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    btlr_bundle_t   mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  fill_reg, fill_next;

    assign full    = fill_reg == FW'(DEPTH);
    assign q_valid = fill_reg != '0;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    `ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FW'(DEPTH),
        "queue fill count exceeds depth")
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, q_valid,
        "queue popped while empty")

endmodule

>>> hw/rtl/btlr_back.sv
// Back end: takes action bundles from the queue and hands out one action
// per transfer, marking the final one. Depends on btlr_pkg and assert_macros.svh.
module btlr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  btlr_pkg::btlr_bundle_t q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             action,
    output logic                   last
);
    import btlr_pkg::*;
    `include "assert_macros.svh"

    logic         busy_reg, busy_next;
    btlr_bundle_t bnd_reg, bnd_next;
    logic [1:0]   idx_reg, idx_next;
    logic         fire;

    assign out_valid = busy_reg;
    assign action    = bnd_reg.act[idx_reg];
    assign last      = idx_reg == (bnd_reg.count - 2'd1);
    assign fire      = busy_reg && out_ready;
    assign pop       = q_valid && (!busy_reg || (fire && last));

    always_comb
    begin
        busy_next = busy_reg;
        bnd_next  = bnd_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            bnd_next  = q_data;
            idx_next  = 2'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bnd_reg <= bnd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    `ASSERT_IMPLY(a_bundle_nonempty, clk, rst_n, busy_reg, bnd_reg.count != 2'd0,
        "held bundle has no actions")
    `ASSERT_NEXT(a_bundle_continues, clk, rst_n, fire && !last,
        busy_reg && (idx_reg == $past(idx_reg) + 2'd1),
        "bundle dropped before its final action")

endmodule

>>> hw/rtl/button_tap_hold_latch_repeat_unit.sv
// Path: an accepted event's actions enter the bundle queue, then the back end's bundle register, before transfer.
// Throughput: one event per cycle while the bundle queue has room; the output side
// moves one action per cycle while m_axis_tready is high.
// Reset: asynchronous, active low; clears the button state, empties the queue and
// returns the configuration to key enabled, tap mode, no mouse action.
module button_tap_hold_latch_repeat_unit #(
    parameter int TIME_BITS   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // now_ms, cursor_on_panel, zero fill
    input  logic [2:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // action, zero fill
    output logic        m_axis_tlast
);
    import btlr_pkg::*;

    btlr_cfg_t    cfg_reg, cfg_next;
    btlr_bundle_t fe_bundle, q_data;
    logic         fe_push, q_full, q_valid, q_pop;
    logic [2:0]   be_action;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_KEY_ENABLED:    cfg_next.key_enabled    = cfg_data[0];
                CFG_BUTTON_MODE:    cfg_next.button_mode    = cfg_data[1:0];
                CFG_MOUSE_ACTION:   cfg_next.mouse_action   = cfg_data;
                CFG_HAS_COMBO:      cfg_next.has_combo      = cfg_data[0];
                CFG_HAS_LONG_COMBO: cfg_next.has_long_combo = cfg_data[0];
                CFG_REPEAT_ENABLE:  cfg_next.repeat_enable  = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{key_enabled: 1'b1, button_mode: 2'd0, mouse_action: 3'd0,
                         has_combo: 1'b0, has_long_combo: 1'b0, repeat_enable: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    btlr_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .opcode          (s_axis_tuser),
        .now_ms          (s_axis_tdata[31:0]),
        .cursor_on_panel (s_axis_tdata[32]),
        .full            (q_full),
        .push            (fe_push),
        .bundle          (fe_bundle)
    );

    btlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_data (fe_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    btlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .action    (be_action),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, be_action};

endmodule

>>> test/button_action_checker.sv
`timescale 1ns / 100ps
// Checker for the button action controller: watches the register port and both streams.
// Predicts the actions of every accepted event and compares each output transfer in order.
// Depends on btlr_pkg for the opcode, action, mode and register index codes.
module button_action_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);
    import btlr_pkg::*;

    typedef struct packed {
        action_t act;
        logic    last;
    } action_item_t;

    action_item_t expected_actions[$];
    action_item_t oldest;
    btlr_cfg_t    cfg;
    int           mismatches;

    logic        is_down, is_latched, is_armed, long_fired;
    logic [31:0] press_time, next_repeat_time, last_toggle_time;

    // True when the wrapping signed difference a - b is below k.
    function automatic logic short_of(input logic [31:0] a, input logic [31:0] b,
                                      input logic [9:0] k);
        logic [31:0] d;
        d = a - b;
        return d[31] || (d < 32'(k));
    endfunction

    task automatic predict_actions(input logic [2:0] op, input logic [31:0] now,
                                   input logic on_panel);
        action_t produced[$];
        logic    latch_mode, hold_mode, tap_mode, mouse_button, mouse_wheel;
        logic    was_down, active;
        latch_mode   = cfg.button_mode == MODE_LATCH;
        hold_mode    = cfg.button_mode == MODE_HOLD;
        tap_mode     = !latch_mode && !hold_mode;
        mouse_button = cfg.mouse_action >= MOUSE_LEFT && cfg.mouse_action <= MOUSE_MIDDLE;
        mouse_wheel  = cfg.mouse_action == MOUSE_WHEEL_UP
                    || cfg.mouse_action == MOUSE_WHEEL_DOWN;
        if (cfg.key_enabled)
        begin
            case (op)
                OP_PRESS:
                begin
                    was_down         = is_down;
                    is_down          = 1'b1;
                    press_time       = now;
                    long_fired       = 1'b0;
                    next_repeat_time = now + 32'(REPEAT_DELAY);
                    if (latch_mode)
                    begin
                        if (!was_down && !short_of(now, last_toggle_time, GHOST_WINDOW))
                        begin
                            last_toggle_time = now;
                            if (is_latched)
                            begin
                                if (!is_armed)
                                    produced.insert(produced.size(), ACT_UP);
                                is_latched = 1'b0;
                                is_armed   = 1'b0;
                            end
                            else
                            begin
                                is_latched = 1'b1;
                                if (mouse_button && on_panel)
                                    is_armed = 1'b1;
                                else
                                    produced.insert(produced.size(), ACT_DOWN);
                            end
                        end
                    end
                    else if (hold_mode)
                    begin
                        if (mouse_button && on_panel)
                            is_armed = 1'b1;
                        else
                            produced.insert(produced.size(), ACT_DOWN);
                    end
                    else if (!cfg.has_long_combo)
                        produced.insert(produced.size(), ACT_TAP);
                end
                OP_RELEASE:
                begin
                    is_down = 1'b0;
                    if (hold_mode)
                    begin
                        if (is_armed)
                            is_armed = 1'b0;
                        else
                            produced.insert(produced.size(), ACT_UP);
                    end
                    else
                    begin
                        if (tap_mode && cfg.has_long_combo && !long_fired)
                            produced.insert(produced.size(), ACT_TAP);
                        long_fired = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    if (is_armed && !on_panel)
                    begin
                        is_armed = 1'b0;
                        produced.insert(produced.size(), ACT_DOWN);
                    end
                    if (is_down && !long_fired && cfg.has_long_combo
                        && !short_of(now, press_time, LONG_PRESS))
                    begin
                        long_fired = 1'b1;
                        produced.insert(produced.size(), ACT_LONG);
                    end
                    if (cfg.repeat_enable)
                    begin
                        active = latch_mode ? is_latched : is_down;
                        if (active && !is_armed && !short_of(now, next_repeat_time, 10'd0))
                        begin
                            next_repeat_time = now + 32'(REPEAT_STEP);
                            if (tap_mode)
                                produced.insert(produced.size(), ACT_TAP);
                            else if (cfg.has_combo)
                                produced.insert(produced.size(), ACT_REPEAT);
                            else if (mouse_wheel)
                                produced.insert(produced.size(), ACT_WHEEL);
                        end
                    end
                end
                OP_FLUSH_ARMED:
                begin
                    if (is_armed)
                    begin
                        is_armed = 1'b0;
                        produced.insert(produced.size(), ACT_DOWN);
                    end
                end
                OP_RELEASE_ALL:
                begin
                    if ((is_latched || is_down) && !is_armed)
                        produced.insert(produced.size(), ACT_UP);
                    is_latched = 1'b0;
                    is_down    = 1'b0;
                    is_armed   = 1'b0;
                    long_fired = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        foreach (produced[i])
            expected_actions.insert(expected_actions.size(),
                                    '{act: produced[i], last: i == produced.size() - 1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg                = '0;
            cfg.key_enabled    = 1'b1;
            is_down            = 1'b0;
            is_latched         = 1'b0;
            is_armed           = 1'b0;
            long_fired         = 1'b0;
            press_time         = '0;
            next_repeat_time   = '0;
            last_toggle_time   = '0;
            mismatches         = 0;
            expected_actions.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_ENABLED:    cfg.key_enabled    = cfg_data[0];
                    CFG_BUTTON_MODE:    cfg.button_mode    = cfg_data[1:0];
                    CFG_MOUSE_ACTION:   cfg.mouse_action   = cfg_data;
                    CFG_HAS_COMBO:      cfg.has_combo      = cfg_data[0];
                    CFG_HAS_LONG_COMBO: cfg.has_long_combo = cfg_data[0];
                    CFG_REPEAT_ENABLE:  cfg.repeat_enable  = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_actions(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[32]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_actions.size() == 0)
                begin
                    $display("%0t: unexpected action, expected none, actual action %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_actions.pop_front();
                    if (m_axis_tdata !== {5'b0, oldest.act} || m_axis_tlast !== oldest.last)
                    begin
                        $display("%0t: expected action %0d last %0b, actual action %0d last %0b",
                                 $time, oldest.act, oldest.last, m_axis_tdata, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            pending <= expected_actions.size();
            errors  <= mismatches;
        end
    end

endmodule

>>> test/button_tap_hold_latch_repeat_unit_test.sv
`timescale 1ns / 100ps
// Top of the button action controller testbench: clock, reset, register writes and events.
// Depends on btlr_pkg, the controller RTL and button_action_checker, which gives the verdict count.
module button_tap_hold_latch_repeat_unit_test;
    import btlr_pkg::*;

    localparam int         CYCLE_LIMIT     = 500000;
    localparam int         TARGET_EVENTS   = 330;
    localparam logic [1:0] MODE_TAP        = 2'd0;
    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam logic [2:0] MOUSE_NONE      = 3'd0;
    localparam logic [2:0] MOUSE_SPARE     = 3'd7;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int          errors;
    int          pending;
    int          cycles = 0;
    int          counted = 0;
    logic        quiet = 1'b0;
    logic        key_on = 1'b1;
    logic [31:0] t_ms = '0;

    button_tap_hold_latch_repeat_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    button_action_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_event(input logic [2:0] op, input logic [31:0] at, input logic panel);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, panel, at};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        counted++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [2:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Registers change only once every expected action has been delivered and
    // any trailing silent events have left the pipeline.
    task automatic apply_config(input logic ke, input logic [1:0] mode, input logic [2:0] mouse,
                                input logic combo, input logic long_combo, input logic rep);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        write_reg(CFG_KEY_ENABLED, {2'b0, ke});
        write_reg(CFG_BUTTON_MODE, {1'b0, mode});
        write_reg(CFG_MOUSE_ACTION, mouse);
        write_reg(CFG_HAS_COMBO, {2'b0, combo});
        write_reg(CFG_HAS_LONG_COMBO, {2'b0, long_combo});
        write_reg(CFG_REPEAT_ENABLE, {2'b0, rep});
        cfg_we <= 1'b0;
        key_on = ke;
    endtask

    task automatic random_gesture();
        int   ticks;
        logic panel;
        if ($urandom_range(0, 9) == 0)
            t_ms = $urandom_range(0, 1) ? 32'hFFFF_FC00 + $urandom_range(0, 1023) : $urandom();
        t_ms  += $urandom_range(0, 400);
        panel  = 1'($urandom_range(0, 1));
        send_event(OP_PRESS, t_ms, panel);
        ticks = $urandom_range(0, 12);
        repeat (ticks)
        begin
            t_ms += $urandom_range(0, 120);
            if ($urandom_range(0, 3) == 0)
                panel = !panel;
            send_event(OP_TICK, t_ms, panel);
            if ($urandom_range(0, 15) == 0)
                send_event(OP_FLUSH_ARMED, t_ms, panel);
        end
        t_ms += $urandom_range(0, 60);
        send_event($urandom_range(0, 7) == 0 ? OP_RELEASE_ALL : OP_RELEASE, t_ms, panel);
        repeat ($urandom_range(0, 3))
        begin
            t_ms += $urandom_range(0, 120);
            send_event(OP_TICK, t_ms, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_noise();
        logic [31:0] at;
        at = $urandom_range(0, 3) == 0 ? $urandom() : t_ms + $urandom_range(0, 600) - 300;
        send_event(3'($urandom_range(0, 7)), at, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int phase;
        int phase_len;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_KEY_ENABLED;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PRESS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_event(OP_PRESS, 32'd0, 1'b0);
        send_event(OP_RELEASE, 32'hFFFF_FFFF, 1'b1);
        send_event(OP_TICK, 32'd0, 1'b0);
        send_event(OP_FLUSH_ARMED, 32'd5, 1'b1);
        send_event(OP_RELEASE_ALL, 32'd10, 1'b0);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_event(3'(op), 32'd20, 1'b1);

        apply_config(1'b1, MODE_LATCH, MOUSE_LEFT, 1'b1, 1'b0, 1'b1);
        send_event(OP_PRESS, 32'd100, 1'b1);
        send_event(OP_RELEASE, 32'd120, 1'b1);
        send_event(OP_PRESS, 32'd1000, 1'b1);
        send_event(OP_TICK, 32'd1010, 1'b1);
        send_event(OP_TICK, 32'd1400, 1'b0);
        send_event(OP_RELEASE, 32'd1401, 1'b0);
        send_event(OP_PRESS, 32'd1200, 1'b0);
        send_event(OP_RELEASE, 32'd1210, 1'b0);
        send_event(OP_PRESS, 32'd2000, 1'b0);
        send_event(OP_RELEASE_ALL, 32'd2001, 1'b0);

        apply_config(1'b1, MODE_HOLD, MOUSE_LEFT, 1'b1, 1'b1, 1'b1);
        send_event(OP_PRESS, 32'hFFFF_FF00, 1'b1);
        send_event(OP_TICK, 32'hFFFF_FF00 + 32'd700, 1'b0);
        send_event(OP_RELEASE, 32'h0000_01C0, 1'b0);
        send_event(OP_PRESS, 32'd500, 1'b1);
        send_event(OP_FLUSH_ARMED, 32'd510, 1'b1);
        send_event(OP_RELEASE_ALL, 32'd520, 1'b0);

        apply_config(1'b0, MODE_SPARE, MOUSE_SPARE, 1'b1, 1'b1, 1'b1);
        send_event(OP_PRESS, 32'd0, 1'b0);
        send_event(OP_RELEASE_ALL, 32'd1, 1'b0);

        phase   = 0;
        while (counted < TARGET_EVENTS)
        begin
            if (phase == 0)
                apply_config(1'b1, MODE_SPARE, MOUSE_SPARE, 1'b1, 1'b1, 1'b1);
            else if (phase == 1)
                apply_config(1'b1, MODE_TAP, MOUSE_NONE, 1'b0, 1'b0, 1'b0);
            else
                apply_config($urandom_range(0, 7) != 0, 2'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            quiet     = $urandom_range(0, 3) == 0;
            phase_len = key_on ? $urandom_range(20, 50) : 6;
            while (phase_len > 0)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    random_gesture();
                    phase_len -= 8;
                end
                else
                begin
                    random_noise();
                    phase_len--;
                end
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
